FILE: hdl/ipf_pkg.sv
package ipf_pkg;
   localparam logic [2:0] FUNC_D = 3'd0;
   localparam logic [2:0] FUNC_U = 3'd1;
   localparam logic [2:0] FUNC_O = 3'd2;
   localparam logic [2:0] FUNC_X = 3'd3;
   localparam logic [2:0] FUNC_XU = 3'd4;
   localparam logic [2:0] FUNC_P = 3'd5;

   localparam logic [1:0] LM_NONE = 2'd0;
   localparam logic [1:0] LM_H = 2'd1;
   localparam logic [1:0] LM_L = 2'd2;
   localparam logic [1:0] LM_LL = 2'd3;

   localparam int unsigned OUT_CAP = 63;

   typedef logic [7:0] char_type;

   function automatic char_type digit_char(input logic [3:0] d, input logic upper);
      char_type c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else if (upper) begin
         c = 8'h37 + {4'd0, d};
      end else begin
         c = 8'h57 + {4'd0, d};
      end
      return c;
   endfunction
endpackage

FILE: hdl/ipf_divider.sv
module ipf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend,
   output logic        done,
   output logic [63:0] quotient,
   output logic [3:0]  remainder
);
   // unsigned 64-bit divide by ten, 16 dividend bits per cycle in four steps
   // chunk quotient by reciprocal multiply, exact for chunks below 10 * 2^16
   localparam logic [20:0] RECIP_TEN = 21'h19999A;

   logic [63:0] quo_ff, quo_in;
   logic [3:0]  rem_ff, rem_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [19:0] chunk;
   logic [40:0] prod;
   logic [15:0] part_q;
   logic [19:0] back;
   logic [19:0] diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      chunk = {rem_ff, quo_ff[63:48]};
      prod = {21'd0, chunk} * {20'd0, RECIP_TEN};
      part_q = prod[39:24];
      // part_q * 10 as 8q + 2q
      back = {1'b0, part_q, 3'b000} + {3'b000, part_q, 1'b0};
      diff = chunk - back;
      if (go) begin
         quo_in = dividend;
         rem_in = 4'd0;
         cnt_in = 2'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[47:0], part_q};
         rem_in = diff[3:0];
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule

FILE: hdl/integer_printf_formatter_unit.sv
// channel   | ports                               | handshake
// ----------+-------------------------------------+--------------------------------
// request   | req_value .. req_precision          | start high while busy low
// result    | rsp_out_char, rsp_last              | rsp_valid high with each character
//
// octal and hex digits come straight from bit slices, one per cycle; decimal
// digits come from the divide-by-ten unit, one digit per division, so a
// 64-bit decimal request converts up to 20 digits before its first
// character, then one cycle per emitted character (at most 63).
// reset is synchronous; it drops any request in flight.
// the receiver cannot stall: every character is shown for exactly one cycle.
module integer_printf_formatter_unit #(
   parameter int unsigned MAX_FIELD = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   input  logic [2:0]  req_func,
   input  logic [1:0]  req_length_mod,
   input  logic        req_flag_left,
   input  logic        req_flag_plus,
   input  logic        req_flag_space,
   input  logic        req_flag_alt,
   input  logic        req_flag_zero,
   input  logic [5:0]  req_width,
   input  logic        req_has_point,
   input  logic [5:0]  req_precision,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last
);
   import ipf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [5:0] MAX_F = 6'(MAX_FIELD);

   logic [2:0]  state_ff, state_in;
   // digit store, least significant first, one register per digit
   logic [3:0]  dig_ff [24];
   logic [3:0]  dig_wr;
   logic        dig_we;
   logic [4:0]  ndig_ff, ndig_in;      // converted digits
   logic [63:0] work_ff, work_in;
   logic [2:0]  func_ff;
   logic        upper_ff, left_ff, zero_ff;
   logic [1:0]  npre_ff, npre_in;
   char_type    pre0_ff, pre1_ff, pre0_in, pre1_in;
   logic        odig_ff, odig_in;      // octal alt leading zero
   logic [5:0]  pz_ff, pad_ff, pz_in, pad_in;
   logic [6:0]  pos_ff, pos_in;        // emitted count
   logic [6:0]  total_ff, total_in;
   logic [5:0]  w_ff, pr_ff;
   logic        plus_ff;
   logic [3:0]  base_ff;

   // request decode, done at accept
   logic [2:0]  f;
   logic        d_left, d_plus, d_space, d_alt, d_zero, d_hp;
   logic [5:0]  d_w, d_pr;
   logic [1:0]  d_lm;
   logic [63:0] m, mag;
   logic        neg;

   logic        div_go, div_done;
   logic [63:0] div_q;
   logic [3:0]  div_r;

   ipf_divider u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(work_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   always_comb begin
      f = req_func;
      d_left = req_flag_left;
      d_plus = req_flag_plus;
      d_space = req_flag_space;
      d_alt = req_flag_alt;
      d_zero = req_flag_zero;
      d_hp = req_has_point;
      d_pr = req_precision;
      d_lm = req_length_mod;
      if (f == FUNC_D) begin
         d_alt = 1'b0;
      end else if (f != FUNC_P) begin
         d_plus = 1'b0;
         d_space = 1'b0;
      end else begin
         d_hp = 1'b0;
         d_pr = 6'd0;
         d_alt = 1'b1;
         d_lm = LM_L;
      end
      if (d_plus) d_space = 1'b0;
      if (d_left) d_zero = 1'b0;
      if (d_pr != 6'd0 || d_hp) d_zero = 1'b0;
      d_w = (req_width > MAX_F) ? MAX_F : req_width;
      if (d_pr > MAX_F) d_pr = MAX_F;
      neg = 1'b0;
      case (d_lm)
         LM_H: begin
            m = {48'd0, req_value[15:0]};
            neg = req_value[15];
         end
         LM_NONE: begin
            m = {32'd0, req_value[31:0]};
            neg = req_value[31];
         end
         default: begin
            m = req_value;
            neg = req_value[63];
         end
      endcase
      neg = neg && (f == FUNC_D);
      mag = m;
      if (neg) begin
         case (d_lm)
            LM_H: mag = {48'd0, 16'(~m[15:0] + 16'd1)};
            LM_NONE: mag = {32'd0, 32'(~m[31:0] + 32'd1)};
            default: mag = ~m + 64'd1;
         endcase
      end
   end

   // next digit for power-of-two radices
   logic [3:0] slice;
   logic [63:0] shifted;
   always_comb begin
      if (func_ff == FUNC_O) begin
         slice = {1'b0, work_ff[2:0]};
         shifted = work_ff >> 3;
      end else begin
         slice = work_ff[3:0];
         shifted = work_ff >> 4;
      end
   end

   // character at emit position
   logic [6:0] p;
   logic [6:0] lead, b_pre, b_zp, b_pz, b_dig;
   logic [5:0] digtot;
   char_type   ch;
   logic [4:0] di;
   always_comb begin
      p = pos_ff;
      digtot = {1'b0, ndig_ff} + {5'd0, odig_ff};
      lead = (!left_ff && !zero_ff) ? {1'b0, pad_ff} : 7'd0;
      b_pre = lead + {5'd0, npre_ff};
      b_zp = b_pre + (zero_ff ? {1'b0, pad_ff} : 7'd0);
      b_pz = b_zp + {1'b0, pz_ff};
      b_dig = b_pz + {1'b0, digtot};
      di = 5'(b_dig - p - 7'd1);
      if (p < lead) ch = 8'h20;
      else if (p < b_pre) ch = (p == lead) ? pre0_ff : pre1_ff;
      else if (p < b_pz) ch = 8'h30;
      else if (p < b_dig) begin
         if (odig_ff && p == b_pz) ch = 8'h30;
         else ch = digit_char(dig_ff[di], upper_ff);
      end else ch = 8'h20;
   end

   logic [5:0] core_w;
   logic [6:0] core_sum;
   always_comb begin
      state_in = state_ff;
      work_in = work_ff;
      ndig_in = ndig_ff;
      npre_in = npre_ff;
      pre0_in = pre0_ff;
      pre1_in = pre1_ff;
      odig_in = odig_ff;
      pz_in = pz_ff;
      pad_in = pad_ff;
      pos_in = pos_ff;
      total_in = total_ff;
      div_go = 1'b0;
      dig_we = 1'b0;
      dig_wr = slice;
      core_w = 6'd0;
      core_sum = 7'd0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               work_in = mag;
               ndig_in = 5'd0;
               pos_in = 7'd0;
               state_in = (req_func > FUNC_P) ? ST_IDLE : ST_DIV;
               if (mag == 64'd0 && !(d_hp && d_pr == 6'd0)) begin
                  // single zero digit
                  ndig_in = 5'd1;
               end
               odig_in = (f == FUNC_O) && d_alt && (mag != 64'd0 || ndig_in == 5'd0);
               npre_in = 2'd0;
               pre0_in = 8'h30;
               pre1_in = (f == FUNC_XU) ? 8'h58 : 8'h78;
               if (f == FUNC_D) begin
                  npre_in = (neg || d_plus || d_space) ? 2'd1 : 2'd0;
                  pre0_in = neg ? 8'h2d : d_plus ? 8'h2b : 8'h20;
               end else if ((f == FUNC_X || f == FUNC_XU) && d_alt && mag != 64'd0) begin
                  npre_in = 2'd2;
               end else if (f == FUNC_P) begin
                  // pointer: optional sign character, then 0x
                  npre_in = (mag != 64'd0 && (d_plus || d_space)) ? 2'd3 : 2'd2;
               end
            end
         end
         ST_DIV: begin
            if (work_ff == 64'd0) begin
               state_in = ST_EMIT;
               core_w = {1'b0, ndig_ff} + {5'd0, odig_ff};
               pz_in = (pr_ff > core_w) ? pr_ff - core_w : 6'd0;
               core_sum = {5'd0, npre_ff} + {1'b0, pz_in} + {1'b0, core_w};
               pad_in = ({1'b0, w_ff} > core_sum) ? 6'(7'(w_ff) - core_sum) : 6'd0;
               total_in = core_sum + {1'b0, pad_in};
               if (total_in > 7'(OUT_CAP)) total_in = 7'(OUT_CAP);
               if (total_in == 7'd0) state_in = ST_IDLE;
            end else if (base_ff == 4'd10) begin
               div_go = 1'b1;
               state_in = ST_WAIT;
            end else begin
               dig_we = 1'b1;
               work_in = shifted;
               ndig_in = ndig_ff + 5'd1;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               dig_we = 1'b1;
               dig_wr = div_r;
               work_in = div_q;
               ndig_in = ndig_ff + 5'd1;
               state_in = ST_DIV;
            end
         end
         ST_EMIT: begin
            pos_in = pos_ff + 7'd1;
            if (pos_in == total_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      ndig_ff <= ndig_in;
      npre_ff <= npre_in;
      pre0_ff <= pre0_in;
      pre1_ff <= pre1_in;
      odig_ff <= odig_in;
      pz_ff <= pz_in;
      pad_ff <= pad_in;
      pos_ff <= pos_in;
      total_ff <= total_in;
      if (dig_we) dig_ff[ndig_ff] <= dig_wr;
      if (state_ff == ST_IDLE && start) begin
         // zero value: store digit 0 (also covered when work is zero)
         dig_ff[0] <= 4'd0;
         func_ff <= f;
         upper_ff <= (f == FUNC_XU);
         left_ff <= d_left;
         zero_ff <= d_zero;
         w_ff <= d_w;
         pr_ff <= d_pr;
         plus_ff <= d_plus;
         base_ff <= (f <= FUNC_U) ? 4'd10 : (f == FUNC_O) ? 4'd8 : 4'd0;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // pointer prefix of three characters reuses the sign slot
   char_type pch;
   always_comb begin
      pch = ch;
      if (func_ff == FUNC_P && npre_ff == 2'd3 && p >= lead && p < b_pre) begin
         if (p == lead) pch = plus_ff ? 8'h2b : 8'h20;
         else if (p == lead + 7'd1) pch = 8'h30;
         else pch = 8'h78;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_out_char = pch;
   assign rsp_last = (state_ff == ST_EMIT) && (pos_ff + 7'd1 == total_ff);
endmodule

FILE: verif/integer_printf_formatter_unit_tb.sv
`timescale 1ns / 1ps

module integer_printf_formatter_unit_tb;
   import ipf_pkg::*;

   localparam int MAX_FLD = 62;

   // one formatted character as seen on the result port
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } fmt_char_type;

   // field characters waiting to come out, oldest first
   class field_scoreboard;
      fmt_char_type pending[$];
      int errors;

      function void note_request(input logic [63:0] value, input logic [2:0] func,
                                 input logic [1:0] lm, input logic left,
                                 input logic plus, input logic space,
                                 input logic alt, input logic zero,
                                 input logic [5:0] width, input logic hp,
                                 input logic [5:0] prec);
         logic [7:0] pre[$];
         logic [7:0] dig[$];
         logic [7:0] seq[$];
         logic [63:0] mask, m, mag, t;
         logic neg;
         int bits, base, w, pr, pz, core, pad, ndig0;
         logic [3:0] d;
         fmt_char_type e;
         neg = 1'b0;
         if (func > FUNC_P) return;
         // drop flags the conversion does not allow
         if (func == FUNC_D) alt = 1'b0;
         else if (func != FUNC_P) begin
            plus = 1'b0;
            space = 1'b0;
         end else begin
            hp = 1'b0;
            prec = 6'd0;
            alt = 1'b1;
            lm = LM_L;
         end
         if (plus) space = 1'b0;
         if (left) zero = 1'b0;
         if (prec != 6'd0 || hp) zero = 1'b0;
         w = (width > MAX_FLD) ? MAX_FLD : width;
         pr = (prec > MAX_FLD) ? MAX_FLD : prec;
         bits = (lm == LM_H) ? 16 : (lm == LM_NONE) ? 32 : 64;
         mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
         m = value & mask;
         mag = m;
         if (func == FUNC_D && m[bits-1]) begin
            neg = 1'b1;
            mag = (~m + 64'd1) & mask;
         end
         base = (func <= FUNC_U) ? 10 : (func == FUNC_O) ? 8 : 16;
         // digits, most significant first
         if (mag == 64'd0) begin
            if (!(hp && pr == 0)) dig.push_back("0");
         end else begin
            t = mag;
            while (t != 64'd0) begin
               d = 4'(t % base);
               if (d < 4'd10) dig.push_front(8'h30 + {4'd0, d});
               else dig.push_front(((func == FUNC_XU) ? 8'h37 : 8'h57) + {4'd0, d});
               t = t / base;
            end
         end
         ndig0 = dig.size();
         // octal alt form: leading zero counts toward precision
         if (func == FUNC_O && alt && (mag != 64'd0 || ndig0 == 0)) dig.push_front("0");
         if (func == FUNC_D) begin
            if (neg) pre.push_back("-");
            else if (plus) pre.push_back("+");
            else if (space) pre.push_back(" ");
         end else if ((func == FUNC_X || func == FUNC_XU) && alt && mag != 64'd0) begin
            pre.push_back("0");
            pre.push_back((func == FUNC_XU) ? "X" : "x");
         end else if (func == FUNC_P) begin
            if (mag != 64'd0) begin
               if (plus) pre.push_back("+");
               else if (space) pre.push_back(" ");
            end
            pre.push_back("0");
            pre.push_back("x");
         end
         pz = (pr > dig.size()) ? pr - dig.size() : 0;
         core = pre.size() + pz + dig.size();
         pad = (w > core) ? w - core : 0;
         if (!left && !zero) repeat (pad) seq.push_back(" ");
         foreach (pre[i]) seq.push_back(pre[i]);
         if (zero) repeat (pad) seq.push_back("0");
         repeat (pz) seq.push_back("0");
         foreach (dig[i]) seq.push_back(dig[i]);
         if (left) repeat (pad) seq.push_back(" ");
         // overlong fields are cut at the output cap
         while (seq.size() > OUT_CAP) void'(seq.pop_back());
         foreach (seq[i]) begin
            e.ch = seq[i];
            e.last = (i == seq.size() - 1);
            pending.push_back(e);
         end
      endfunction

      task check_char(input logic [7:0] ch, input logic last);
         fmt_char_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected char %h last %b", ch, last));
            return;
         end
         e = pending.pop_front();
         if (ch !== e.ch) report_mismatch($sformatf("char %h, want %h", ch, e.ch));
         if (last !== e.last) report_mismatch($sformatf("last %b, want %b", last, e.last));
      endtask

      task report_mismatch(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_value = '0;
   logic [2:0]  req_func = '0;
   logic [1:0]  req_length_mod = '0;
   logic        req_flag_left = 1'b0;
   logic        req_flag_plus = 1'b0;
   logic        req_flag_space = 1'b0;
   logic        req_flag_alt = 1'b0;
   logic        req_flag_zero = 1'b0;
   logic [5:0]  req_width = '0;
   logic        req_has_point = 1'b0;
   logic [5:0]  req_precision = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;

   field_scoreboard sb = new();

   always #4 clock = ~clock;

   integer_printf_formatter_unit dut (.*);

   // every strobed character is checked at the edge that ends its cycle
   always @(posedge clock)
      if (!reset && rsp_valid) sb.check_char(rsp_out_char, rsp_last);

   // a short or, now and then, a long idle gap between requests
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      repeat (n) @(posedge clock);
   endtask

   // present one request and hold it until the block takes it
   task automatic send_request(input logic [63:0] v, input logic [2:0] f,
                               input logic [1:0] lm, input logic [4:0] flags,
                               input logic [5:0] w, input logic hp,
                               input logic [5:0] p);
      start <= 1'b1;
      req_value <= v;
      req_func <= f;
      req_length_mod <= lm;
      {req_flag_left, req_flag_plus, req_flag_space, req_flag_alt, req_flag_zero} <= flags;
      req_width <= w;
      req_has_point <= hp;
      req_precision <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(v, f, lm, flags[4], flags[3], flags[2], flags[1], flags[0], w, hp, p);
      start <= 1'b0;
      @(posedge clock);
   endtask

   // random request: mostly sane widths, sometimes the extremes
   task automatic send_random();
      logic [63:0] v;
      logic [5:0] w, p;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: v = '0;
         1: v = v >> $urandom_range(0, 63);
         default: ;
      endcase
      w = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
      p = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
      send_request(v, ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                   : 3'($urandom_range(0, 5)), 2'($urandom), 5'($urandom), w,
                   1'($urandom), p);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, every conversion and the special cases
      send_request(64'h8000_0000, FUNC_D, LM_NONE, 5'b00000, 6'd0, 1'b0, 6'd0);
      send_request(64'h8000_0000_0000_0000, FUNC_D, LM_L, 5'b01000, 6'd0, 1'b0, 6'd0);
      send_request('1, FUNC_U, LM_LL, 5'b00000, 6'd0, 1'b0, 6'd0);
      send_request(64'h1234, FUNC_D, LM_H, 5'b01100, 6'd10, 1'b0, 6'd0);
      send_request(64'h7fff, FUNC_D, LM_H, 5'b00100, 6'd0, 1'b0, 6'd0);
      send_request(64'd0, FUNC_D, LM_NONE, 5'b00000, 6'd0, 1'b1, 6'd0);   // empty field
      send_request(64'd0, FUNC_D, LM_NONE, 5'b00000, 6'd5, 1'b1, 6'd0);
      send_request(64'd0, FUNC_O, LM_NONE, 5'b00010, 6'd0, 1'b1, 6'd0);   // octal alt zero
      send_request(64'o777, FUNC_O, LM_NONE, 5'b00010, 6'd0, 1'b1, 6'd5);
      send_request(64'hbeef, FUNC_X, LM_NONE, 5'b00011, 6'd12, 1'b0, 6'd0);
      send_request(64'hbeef, FUNC_XU, LM_NONE, 5'b00010, 6'd12, 1'b1, 6'd8);
      send_request(64'd0, FUNC_X, LM_NONE, 5'b00010, 6'd4, 1'b0, 6'd0);
      send_request(64'd0, FUNC_P, LM_H, 5'b01000, 6'd0, 1'b1, 6'd9);      // null pointer
      send_request(64'hdead_beef_cafe, FUNC_P, LM_H, 5'b00100, 6'd20, 1'b0, 6'd0);
      send_request(64'h42, FUNC_P, LM_NONE, 5'b11001, 6'd20, 1'b0, 6'd0);
      send_request(64'h42, FUNC_D, LM_NONE, 5'b10001, 6'd63, 1'b0, 6'd0);
      send_request(64'h42, FUNC_D, LM_NONE, 5'b00001, 6'd63, 1'b0, 6'd0);
      send_request(64'h42, FUNC_U, LM_NONE, 5'b00001, 6'd10, 1'b1, 6'd63); // overlong
      send_request('1, FUNC_O, LM_L, 5'b01110, 6'd62, 1'b0, 6'd62);
      send_request(64'h5, 3'd6, LM_NONE, 5'b11111, 6'd10, 1'b0, 6'd0);   // unknown
      send_request(64'h5, 3'd7, LM_NONE, 5'b00000, 6'd10, 1'b0, 6'd0);
      // hold off until the field queue drains
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) begin
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) @(posedge clock);
         send_random();
         if ($urandom_range(0, 2) == 0) idle_gap();
      end
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #8000000;
      $display("Verification failed");
      $finish;
   end
endmodule

FILE: sim.f
hdl/ipf_pkg.sv
hdl/ipf_divider.sv
hdl/integer_printf_formatter_unit.sv
verif/integer_printf_formatter_unit_tb.sv
